### rtl/core/tsts_pkg.sv
// Shared definitions for the time slot table scheduler: field widths,
// opcodes and parameter defaults.
// No dependencies.
package tsts_pkg;

  // Field widths of the input and result transfers
  localparam int OPCODE_W   = 2;
  localparam int OWNER_W    = 8;
  localparam int RANGE_W    = 7;
  localparam int SLOT_W     = 32;
  localparam int DEADLINE_W = 53;

  // Parameter defaults
  localparam int SLOT_COUNT_DEF = 64;
  localparam int SLOT_TICKS_DEF = 1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FETCH  = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

endpackage

### rtl/core/tsts_ifs.sv
// Valid/ready channel interfaces for the time slot table scheduler.
// Depends on tsts_pkg for the field widths.
interface tsts_in_if;
  logic                             valid;
  logic                             ready;
  logic [tsts_pkg::OPCODE_W-1:0]    opcode;
  logic [tsts_pkg::OWNER_W-1:0]     owner_id;
  logic [tsts_pkg::RANGE_W-1:0]     range_begin;
  logic [tsts_pkg::RANGE_W-1:0]     range_end;
  logic [tsts_pkg::SLOT_W-1:0]      slot_number;

  modport source (output valid, opcode, owner_id, range_begin, range_end, slot_number,
                  input ready);
  modport sink   (input valid, opcode, owner_id, range_begin, range_end, slot_number,
                  output ready);
endinterface

interface tsts_out_if;
  logic                             valid;
  logic                             ready;
  logic                             grant_valid;
  logic [tsts_pkg::OWNER_W-1:0]     granted_owner;
  logic [tsts_pkg::DEADLINE_W-1:0]  deadline;

  modport source (output valid, grant_valid, granted_owner, deadline, input ready);
  modport sink   (input valid, grant_valid, granted_owner, deadline, output ready);
endinterface

### rtl/core/time_slot_table_scheduler_unit.sv
// Fetch: reciprocal multiply, remainder, table read, add and multiply lead to the result
// register, loaded once the output is free; the next transfer is taken after that.
// Assign/delete: one table write per slot in range, then the result; an empty range writes none.
// Reset (synchronous, rst_n low) starts a clearing pass over every slot that
// writes the reset contents into both tables; in_chan.ready stays low meanwhile.
// The result register lets a new transfer in while the last result waits.
module time_slot_table_scheduler_unit #(
  parameter int SLOT_COUNT = tsts_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_TICKS = tsts_pkg::SLOT_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tsts_in_if.sink     in_chan,
  tsts_out_if.source  out_chan
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int REM_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int PTR_W  = (CNT_W > tsts_pkg::RANGE_W) ? CNT_W : tsts_pkg::RANGE_W;
  localparam int TICK_W = $clog2(SLOT_TICKS + 1);
  localparam int SUM_W  = tsts_pkg::SLOT_W + 1;
  localparam int PROD_W = SUM_W + TICK_W;
  localparam int DL_W   = tsts_pkg::DEADLINE_W;
  localparam int OWN_W  = tsts_pkg::OWNER_W;

  // Reciprocal of SLOT_COUNT, rounded up, exact for every 32-bit slot number
  localparam int QUOT_W = tsts_pkg::SLOT_W;
  localparam int RCP_SH = $clog2(SLOT_COUNT) + QUOT_W;
  localparam int RCP_W  = QUOT_W + 1;
  localparam int QP_W   = QUOT_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MOD   = 8'b00000010,
    S_REM   = 8'b00000100,
    S_READ  = 8'b00001000,
    S_SUM   = 8'b00010000,
    S_MUL   = 8'b00100000,
    S_SWEEP = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  // Table memories
  logic [OWN_W-1:0] owner_mem [SLOT_COUNT];
  logic [CNT_W-1:0] rem_mem   [SLOT_COUNT];

  state_t                    state_r, state_nxt;
  logic                      clr_r, clr_nxt;
  tsts_pkg::opcode_t         op_r, op_nxt;
  logic [OWN_W-1:0]          owner_r, owner_nxt;
  logic [PTR_W-1:0]          ptr_r, ptr_nxt;
  logic [PTR_W-1:0]          end_r, end_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [tsts_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [QUOT_W-1:0]         quot_r, quot_nxt;
  logic [IDX_W-1:0]          mod_r, mod_nxt;
  logic                      hit_r, hit_nxt;
  logic [OWN_W-1:0]          gown_r, gown_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [DL_W-1:0]           dl_r, dl_nxt;
  logic                      out_grant_r, out_grant_nxt;
  logic [OWN_W-1:0]          out_owner_r, out_owner_nxt;
  logic [DL_W-1:0]           out_dl_r, out_dl_nxt;

  logic [OWN_W-1:0]          rd_owner_r;
  logic [CNT_W-1:0]          rd_len_r;

  logic                      in_xfer;
  logic                      out_free;
  logic [PTR_W-1:0]          in_end_c;
  logic [PTR_W-1:0]          ptr_inc;
  logic [QP_W-1:0]           quot_prod;
  logic [IDX_W-1:0]          qd_low;
  logic [IDX_W-1:0]          mod_idx;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          wr_addr;
  logic                      rem_we;
  logic                      own_we;
  logic [CNT_W-1:0]          wr_len;
  logic [PROD_W-1:0]         prod;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign in_xfer                = in_chan.valid && in_chan.ready;
  assign out_free               = !out_valid_r || out_chan.ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.grant_valid   = out_grant_r;
  assign out_chan.granted_owner = out_owner_r;
  assign out_chan.deadline      = out_dl_r;

  // Clamp range end to the table size
  always_comb begin
    in_end_c = PTR_W'(in_chan.range_end);
    if (in_end_c > PTR_W'(SLOT_COUNT)) begin
      in_end_c = PTR_W'(SLOT_COUNT);
    end
  end

  // Slot remainder: remainder is below the table size, so low index bits suffice
  assign quot_prod = QP_W'(slot_r) * QP_W'(RCP);
  assign qd_low    = IDX_W'(quot_r * QUOT_W'(SLOT_COUNT));
  assign mod_idx   = slot_r[IDX_W-1:0] - qd_low;

  assign ptr_inc   = ptr_r + PTR_W'(1);
  assign rd_addr   = mod_r;
  assign wr_addr   = ptr_r[IDX_W-1:0];
  assign rem_we    = (state_r == S_SWEEP);
  assign own_we    = (state_r == S_SWEEP) && (op_r == tsts_pkg::OP_ASSIGN);
  assign wr_len    = (op_r == tsts_pkg::OP_ASSIGN) ? CNT_W'(end_r - ptr_r) : '0;
  assign prod      = sum_r * PROD_W'(SLOT_TICKS);

  // Control and datapath next state
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    owner_nxt     = owner_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r;
    slot_nxt      = slot_r;
    quot_nxt      = quot_r;
    mod_nxt       = mod_r;
    hit_nxt       = hit_r;
    gown_nxt      = gown_r;
    sum_nxt       = sum_r;
    dl_nxt        = dl_r;
    out_grant_nxt = out_grant_r;
    out_owner_nxt = out_owner_r;
    out_dl_nxt    = out_dl_r;

    // result taken downstream
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt      = tsts_pkg::opcode_t'(in_chan.opcode);
          owner_nxt   = in_chan.owner_id;
          ptr_nxt     = PTR_W'(in_chan.range_begin);
          end_nxt     = in_end_c;
          slot_nxt    = in_chan.slot_number;
          hit_nxt     = 1'b0;
          unique case (tsts_pkg::opcode_t'(in_chan.opcode)) inside
            tsts_pkg::OP_FETCH: state_nxt = S_MOD;
            tsts_pkg::OP_ASSIGN, tsts_pkg::OP_DELETE: begin
              state_nxt = (PTR_W'(in_chan.range_begin) < in_end_c) ? S_SWEEP : S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // quotient by reciprocal multiplication
      S_MOD: begin
        quot_nxt  = QUOT_W'(quot_prod >> RCP_SH);
        state_nxt = S_REM;
      end
      S_REM: begin
        mod_nxt   = mod_idx;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        hit_nxt   = (rd_len_r != '0);
        gown_nxt  = rd_owner_r;
        sum_nxt   = SUM_W'(slot_r) + SUM_W'(rd_len_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        dl_nxt    = DL_W'(prod);
        state_nxt = S_DONE;
      end
      // one table write per cycle
      S_SWEEP: begin
        ptr_nxt = ptr_inc;
        if (ptr_inc == end_r) begin
          state_nxt = clr_r ? S_IDLE : S_DONE;
          clr_nxt   = 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_grant_nxt = hit_r;
          out_owner_nxt = hit_r ? gown_r : '0;
          out_dl_nxt    = hit_r ? dl_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers; reset launches the clearing pass as a full-table assign of owner 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      clr_r       <= 1'b1;
      op_r        <= tsts_pkg::OP_ASSIGN;
      owner_r     <= '0;
      ptr_r       <= '0;
      end_r       <= PTR_W'(SLOT_COUNT);
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      op_r        <= op_nxt;
      owner_r     <= owner_nxt;
      ptr_r       <= ptr_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    quot_r      <= quot_nxt;
    mod_r       <= mod_nxt;
    gown_r      <= gown_nxt;
    sum_r       <= sum_nxt;
    dl_r        <= dl_nxt;
    out_grant_r <= out_grant_nxt;
    out_owner_r <= out_owner_nxt;
    out_dl_r    <= out_dl_nxt;
  end

  // Table memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[wr_addr] <= owner_r;
    end
    if (rem_we) begin
      rem_mem[wr_addr] <= wr_len;
    end
    if (state_r == S_READ) begin
      rd_owner_r <= owner_mem[rd_addr];
      rd_len_r   <= rem_mem[rd_addr];
    end
  end

  // Checks
  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (ptr_r < end_r) && (end_r <= PTR_W'(SLOT_COUNT)))
    else $error("sweep pointer out of range");

  a_mod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (REM_W'(mod_r) < REM_W'(SLOT_COUNT)))
    else $error("slot remainder not below table size");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_grant_r) |-> (out_owner_r == '0) && (out_dl_r == '0))
    else $error("result without grant carries owner or deadline");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (state_r == S_SWEEP) && !out_valid_r)
    else $error("clearing pass overlapped other work");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for time_slot_table_scheduler_unit: directed table cases, then
// random fetch/assign/delete/no-op traffic, first back to back, then with random idling on both channels.
// Depends on tsts_pkg and the channel interfaces in tsts_ifs.sv.
module tb_top;

  localparam int SLOT_COUNT = tsts_pkg::SLOT_COUNT_DEF;
  localparam int SLOT_TICKS = tsts_pkg::SLOT_TICKS_DEF;

  typedef struct {
    tsts_pkg::opcode_t                op;
    logic [tsts_pkg::OWNER_W-1:0]     owner;
    logic [tsts_pkg::RANGE_W-1:0]     rbeg;
    logic [tsts_pkg::RANGE_W-1:0]     rend;
    logic [tsts_pkg::SLOT_W-1:0]      slot;
  } slot_req_t;

  typedef struct {
    logic                             grant;
    logic [tsts_pkg::OWNER_W-1:0]     owner;
    logic [tsts_pkg::DEADLINE_W-1:0]  deadline;
  } grant_t;

  logic clk;
  logic rst_n;

  tsts_in_if  in_if ();
  tsts_out_if out_if ();

  time_slot_table_scheduler_unit #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_TICKS (SLOT_TICKS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Mirror of the slot table and the grants still owed by the block
  logic [tsts_pkg::OWNER_W-1:0] owner_mirror [SLOT_COUNT];
  logic [tsts_pkg::RANGE_W-1:0] length_mirror [SLOT_COUNT];
  grant_t                       pending_grants [$];

  bit stalls_on;
  int fails;
  int checked;
  int n_granted, n_denied, n_assigns, n_deletes, n_noops;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Table update and grant computation for one accepted transfer
  function automatic grant_t table_step(slot_req_t r);
    grant_t      g;
    int unsigned last;
    int unsigned idx;
    logic [63:0] span;
    g = '{grant: 1'b0, owner: '0, deadline: '0};
    last = (r.rend > SLOT_COUNT) ? SLOT_COUNT : r.rend;
    case (r.op)
      tsts_pkg::OP_FETCH: begin
        idx = r.slot % SLOT_COUNT;
        if (length_mirror[idx] != 0) begin
          span = (64'(r.slot) + 64'(length_mirror[idx])) * 64'(SLOT_TICKS);
          g.grant    = 1'b1;
          g.owner    = owner_mirror[idx];
          g.deadline = span[tsts_pkg::DEADLINE_W-1:0];
          n_granted++;
        end else begin
          n_denied++;
        end
      end
      tsts_pkg::OP_ASSIGN: begin
        if (r.rbeg >= last) n_noops++;
        else n_assigns++;
        for (int i = r.rbeg; i < last; i++) begin
          owner_mirror[i]  = r.owner;
          length_mirror[i] = tsts_pkg::RANGE_W'(last - i);
        end
      end
      tsts_pkg::OP_DELETE: begin
        if (r.rbeg >= last) n_noops++;
        else n_deletes++;
        for (int i = r.rbeg; i < last; i++)
          length_mirror[i] = '0;
      end
      default: n_noops++;
    endcase
    return g;
  endfunction

  function automatic slot_req_t mk_req(tsts_pkg::opcode_t op, int owner, int rbeg, int rend,
                                       logic [tsts_pkg::SLOT_W-1:0] slot);
    slot_req_t r;
    r.op    = op;
    r.owner = tsts_pkg::OWNER_W'(owner);
    r.rbeg  = tsts_pkg::RANGE_W'(rbeg);
    r.rend  = tsts_pkg::RANGE_W'(rend);
    r.slot  = slot;
    return r;
  endfunction

  // Mostly short well-formed ranges, some wide ones, some raw 7-bit noise
  function automatic slot_req_t random_req();
    slot_req_t r;
    int        roll;
    int        b;
    int        len;
    roll = $urandom_range(99);
    if (roll < 55)      r.op = tsts_pkg::OP_FETCH;
    else if (roll < 80) r.op = tsts_pkg::OP_ASSIGN;
    else if (roll < 95) r.op = tsts_pkg::OP_DELETE;
    else                r.op = tsts_pkg::OP_NONE;
    r.owner = tsts_pkg::OWNER_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 70)      r.slot = $urandom;
    else if (roll < 85) r.slot = tsts_pkg::SLOT_W'($urandom_range(255));
    else                r.slot = 32'hFFFF_FFFF - tsts_pkg::SLOT_W'($urandom_range(127));
    if ($urandom_range(99) < 85) begin
      b = $urandom_range(SLOT_COUNT - 1);
      if ($urandom_range(9) == 0) len = $urandom_range(SLOT_COUNT - b, 1);
      else len = $urandom_range((SLOT_COUNT - b < 8) ? SLOT_COUNT - b : 8, 1);
      r.rbeg = tsts_pkg::RANGE_W'(b);
      r.rend = tsts_pkg::RANGE_W'(b + len);
    end else begin
      r.rbeg = tsts_pkg::RANGE_W'($urandom_range(127));
      r.rend = tsts_pkg::RANGE_W'($urandom_range(127));
    end
    return r;
  endfunction

  // One input transfer; valid stays up afterwards so back-to-back items need no re-raise
  task automatic send_item(slot_req_t r);
    while (stalls_on && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= r.op;
    in_if.owner_id    <= r.owner;
    in_if.range_begin <= r.rbeg;
    in_if.range_end   <= r.rend;
    in_if.slot_number <= r.slot;
    do @(posedge clk); while (!in_if.ready);
    pending_grants.push_back(table_step(r));
  endtask

  // Result side: random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(stalls_on && $urandom_range(99) < 11);
    end
  end

  // Compare every result transfer with the oldest owed grant
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result grant=%0b owner=%0d deadline=%0d", $time,
                 out_if.grant_valid, out_if.granted_owner, out_if.deadline);
        fails++;
      end else begin
        want = pending_grants.pop_front();
        checked++;
        if (out_if.grant_valid !== want.grant) begin
          $display("%0t: grant_valid expected %0b got %0b", $time, want.grant,
                   out_if.grant_valid);
          fails++;
        end
        if (out_if.granted_owner !== want.owner) begin
          $display("%0t: granted_owner expected %0d got %0d", $time, want.owner,
                   out_if.granted_owner);
          fails++;
        end
        if (out_if.deadline !== want.deadline) begin
          $display("%0t: deadline expected %0d got %0d", $time, want.deadline,
                   out_if.deadline);
          fails++;
        end
      end
    end
  end

  // Table as it comes out of the clearing pass, wrap of the slot number
  task automatic test_reset_contents();
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd0));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd63));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd64));
    send_item(mk_req(tsts_pkg::OP_FETCH, 255, 127, 127, 32'hFFFF_FFFF));
  endtask

  // Full, clamped, empty and inverted ranges; deleted slices; unused opcode
  task automatic test_range_edges();
    send_item(mk_req(tsts_pkg::OP_ASSIGN, 255, 0, 64, 32'd0));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd5));
    send_item(mk_req(tsts_pkg::OP_ASSIGN, 8'hA5, 10, 127, 32'hFFFF_FFFF));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd10));
    send_item(mk_req(tsts_pkg::OP_DELETE, 0, 20, 30, 32'd0));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd25));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd30));
    send_item(mk_req(tsts_pkg::OP_ASSIGN, 17, 40, 40, 32'd0));
    send_item(mk_req(tsts_pkg::OP_ASSIGN, 17, 50, 30, 32'd0));
    send_item(mk_req(tsts_pkg::OP_DELETE, 0, 100, 127, 32'd0));
    send_item(mk_req(tsts_pkg::OP_NONE, 8'h5A, 0, 64, 32'hFFFF_FFFF));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd40));
    send_item(mk_req(tsts_pkg::OP_ASSIGN, 0, 63, 64, 32'd0));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(mk_req(tsts_pkg::OP_DELETE, 0, 0, 127, 32'd0));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'd0));
    send_item(mk_req(tsts_pkg::OP_FETCH, 0, 0, 0, 32'hFFFF_FFC0));
  endtask

  task automatic test_random_back_to_back(int count);
    stalls_on = 1'b0;
    repeat (count) send_item(random_req());
    stalls_on = 1'b1;
  endtask

  task automatic test_random_with_stalls(int count);
    repeat (count) send_item(random_req());
  endtask

  // Drop valid, collect the remaining grants, then watch for stray results
  task automatic drain_results();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_grants.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (pending_grants.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_grants.size());
      fails++;
    end
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      owner_mirror[i]  = '0;
      length_mirror[i] = tsts_pkg::RANGE_W'(SLOT_COUNT - i);
    end
    stalls_on = 1'b1;
    fails = 0;
    checked = 0;
    rst_n <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= tsts_pkg::OP_FETCH;
    in_if.owner_id    <= '0;
    in_if.range_begin <= '0;
    in_if.range_end   <= '0;
    in_if.slot_number <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_contents();
    test_range_edges();
    test_random_back_to_back(220);
    test_random_with_stalls(810);
    drain_results();

    $display("checked %0d results: %0d grants, %0d denied fetches", checked, n_granted,
             n_denied);
    $display("table writes: %0d assigns, %0d deletes, %0d no-op items", n_assigns,
             n_deletes, n_noops);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### time_slot_table_scheduler_unit.f
rtl/core/tsts_pkg.sv
rtl/core/tsts_ifs.sv
rtl/core/time_slot_table_scheduler_unit.sv
tb/sv/tb_top.sv
